FILE: src/nntb_pkg.sv
// Shared types and constants for the nearest-neighbor tour builder.
`timescale 1ns / 1ps

package nntb_pkg;

    localparam int unsigned MAX_CITIES = 16;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned COUNT_W    = 5;
    localparam int unsigned DIST_W     = 10;
    localparam int unsigned ROW_W      = 4;
    localparam int unsigned CITY_W     = 4;
    localparam int unsigned POS_W      = 5;
    localparam int unsigned COST_W     = 14;

    localparam logic [CFG_IDX_W-1:0] REG_CITY_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING    = 1'b1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic [COUNT_W-1:0] CITY_COUNT_RESET = 5'd15;
    localparam logic [DIST_W-1:0]  CEILING_RESET    = 10'd999;
    localparam logic [COST_W-1:0]  COST_MAX         = 14'd16383;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_SCAN,
        ST_STEP,
        ST_RET_RD,
        ST_RET_WAIT,
        ST_RET_EMIT
    } t_state;

endpackage

FILE: src/nearest_neighbour_tour_builder_unit.sv
// Nearest-neighbor tour builder: distance matrix memory, row scan sequencer, result register.
`timescale 1ns / 1ps
// A load item is accepted while idle, and loads go back to back.
// A start item holds the input stalled until its run ends (n = city count in use):
// first the first result, then each of the n-1 steps scans one matrix row,
// one entry per cycle, then a compare and a result step; the return leg reads, waits, emits.
// Results wait in one output register, so downstream stall lengthens the run.
// Reset (sync, active low) clears control, visited set, cost and config; matrix undefined.

module nearest_neighbour_tour_builder_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_op,
    input  logic [nntb_pkg::ROW_W-1:0]    i_row,
    input  logic [nntb_pkg::ROW_W-1:0]    i_col,
    input  logic [nntb_pkg::DIST_W-1:0]   i_distance,
    // result output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [nntb_pkg::POS_W-1:0]    o_position,
    output logic [nntb_pkg::CITY_W-1:0]   o_city,
    output logic [nntb_pkg::DIST_W-1:0]   o_leg_cost,
    output logic [nntb_pkg::COST_W-1:0]   o_total_cost,
    output logic                          o_last,
    output logic                          o_no_city_error,
    // config write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [nntb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nntb_pkg::DIST_W-1:0]   i_cfg_data
);
    import nntb_pkg::*;

    // city index, step/count and matrix address widths
    localparam int unsigned CIW   = (MAX_CITIES > 2) ? $clog2(MAX_CITIES) : 1;
    localparam int unsigned SW    = $clog2(MAX_CITIES + 1);
    localparam int unsigned DEPTH = MAX_CITIES * MAX_CITIES;
    localparam int unsigned AW    = $clog2(DEPTH);

    // distance matrix, one write and one registered read per cycle
    logic [DIST_W-1:0] mem_dist [DEPTH];
    logic [DIST_W-1:0] r_rd_data;

    t_state r_state, n_state;

    logic [COUNT_W-1:0]    r_city_count;
    logic [DIST_W-1:0]     r_ceiling;

    logic [MAX_CITIES-1:0] r_visited, n_visited;
    logic [CIW-1:0]        r_cur, n_cur;
    logic [COST_W-1:0]     r_cost, n_cost;
    logic [SW-1:0]         r_step, n_step;
    logic [SW-1:0]         r_scan, n_scan;

    // compare stage: candidate whose read is in flight, and running best
    logic                  r_cand_ok, n_cand_ok;
    logic [CIW-1:0]        r_cand, n_cand;
    logic [DIST_W-1:0]     r_best, n_best;
    logic [CIW-1:0]        r_pick, n_pick;
    logic                  r_found, n_found;

    // output register
    logic                  r_out_valid, n_out_valid;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [CITY_W-1:0]     r_city, n_city;
    logic [DIST_W-1:0]     r_leg, n_leg;
    logic [COST_W-1:0]     r_total, n_total;
    logic                  r_last, n_last;
    logic                  r_err, n_err;

    logic                  w_in_acc;
    logic                  w_slot;
    logic [SW-1:0]         w_n;
    logic                  w_rd_en;
    logic [AW-1:0]         w_rd_addr;
    logic [CIW-1:0]        w_scan_idx;
    logic [DIST_W-1:0]     w_add_leg;
    logic [COST_W:0]       w_sum;
    logic [COST_W-1:0]     w_sum_sat;
    logic                  w_load_ok;
    logic [AW-1:0]         w_wr_addr;

    assign o_stall     = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_valid && !o_stall;
    // result slot is free when empty or being taken this cycle
    assign w_slot      = !r_out_valid || !i_stall;

    // city count saturated to 2 .. MAX_CITIES
    always_comb begin
        if (r_city_count < COUNT_W'(2)) begin
            w_n = SW'(2);
        end else if (32'(r_city_count) > MAX_CITIES) begin
            w_n = SW'(MAX_CITIES);
        end else begin
            w_n = SW'(r_city_count);
        end
    end

    assign w_scan_idx = r_scan[CIW-1:0];

    // load path: out-of-range rows and columns are dropped
    assign w_load_ok = (32'(i_row) < MAX_CITIES) && (32'(i_col) < MAX_CITIES);
    assign w_wr_addr = AW'(CIW'(i_row)) * AW'(MAX_CITIES) + AW'(CIW'(i_col));

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_op == OP_LOAD && w_load_ok) begin
            mem_dist[w_wr_addr] <= i_distance;
        end
        if (w_rd_en) begin
            r_rd_data <= mem_dist[w_rd_addr];
        end
    end

    // shared saturating cost adder: scan winner or return leg
    assign w_add_leg = (r_state == ST_STEP) ? r_best : r_rd_data;
    assign w_sum     = {1'b0, r_cost} + (COST_W + 1)'(w_add_leg);
    assign w_sum_sat = (w_sum > {1'b0, COST_MAX}) ? COST_MAX : w_sum[COST_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_visited   = r_visited;
        n_cur       = r_cur;
        n_cost      = r_cost;
        n_step      = r_step;
        n_scan      = r_scan;
        n_cand_ok   = 1'b0;
        n_cand      = r_cand;
        n_best      = r_best;
        n_pick      = r_pick;
        n_found     = r_found;
        n_out_valid = r_out_valid && i_stall;
        n_pos       = r_pos;
        n_city      = r_city;
        n_leg       = r_leg;
        n_total     = r_total;
        n_last      = r_last;
        n_err       = r_err;
        w_rd_en     = 1'b0;
        w_rd_addr   = AW'(r_cur) * AW'(MAX_CITIES);

        // strict less-than over ascending indexes keeps the lowest index on ties
        if (r_cand_ok && r_rd_data < r_best) begin
            n_best  = r_rd_data;
            n_pick  = r_cand;
            n_found = 1'b1;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && i_op == OP_START) begin
                    n_visited    = '0;
                    n_visited[0] = 1'b1;
                    n_cur        = '0;
                    n_cost       = '0;
                    n_state      = ST_FIRST;
                end
            end
            ST_FIRST: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_pos       = '0;
                    n_city      = '0;
                    n_leg       = '0;
                    n_total     = '0;
                    n_last      = 1'b0;
                    n_err       = 1'b0;
                    n_step      = SW'(1);
                    n_scan      = '0;
                    n_best      = r_ceiling;
                    n_found     = 1'b0;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_scan < w_n) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = AW'(r_cur) * AW'(MAX_CITIES) + AW'(w_scan_idx);
                    n_cand_ok = !r_visited[w_scan_idx] && (w_scan_idx != r_cur);
                    n_cand    = w_scan_idx;
                    n_scan    = r_scan + SW'(1);
                end else begin
                    // last compare lands at this edge
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_pos       = POS_W'(r_step);
                    if (r_found) begin
                        n_city            = CITY_W'(r_pick);
                        n_leg             = r_best;
                        n_total           = w_sum_sat;
                        n_last            = 1'b0;
                        n_err             = 1'b0;
                        n_cost            = w_sum_sat;
                        n_cur             = r_pick;
                        n_visited[r_pick] = 1'b1;
                        if (r_step == w_n - SW'(1)) begin
                            n_state = ST_RET_RD;
                        end else begin
                            n_step  = r_step + SW'(1);
                            n_scan  = '0;
                            n_best  = r_ceiling;
                            n_found = 1'b0;
                            n_state = ST_SCAN;
                        end
                    end else begin
                        // nothing eligible: close the run with the error flag
                        n_city  = '0;
                        n_leg   = '0;
                        n_total = r_cost;
                        n_last  = 1'b1;
                        n_err   = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_RET_RD: begin
                w_rd_en = 1'b1;
                n_state = ST_RET_WAIT;
            end
            ST_RET_WAIT: begin
                n_state = ST_RET_EMIT;
            end
            ST_RET_EMIT: begin
                // return leg ignores the ceiling
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_pos       = POS_W'(w_n);
                    n_city      = '0;
                    n_leg       = r_rd_data;
                    n_total     = w_sum_sat;
                    n_last      = 1'b1;
                    n_err       = 1'b0;
                    n_cost      = w_sum_sat;
                    n_cur       = '0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_cand_ok   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cand_ok   <= n_cand_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visited <= '0;
            r_cur     <= '0;
            r_cost    <= '0;
        end else begin
            r_visited <= n_visited;
            r_cur     <= n_cur;
            r_cost    <= n_cost;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step  <= n_step;
        r_scan  <= n_scan;
        r_cand  <= n_cand;
        r_best  <= n_best;
        r_pick  <= n_pick;
        r_found <= n_found;
        r_pos   <= n_pos;
        r_city  <= n_city;
        r_leg   <= n_leg;
        r_total <= n_total;
        r_last  <= n_last;
        r_err   <= n_err;
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_city_count <= CITY_COUNT_RESET;
            r_ceiling    <= CEILING_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_CITY_COUNT: r_city_count <= i_cfg_data[COUNT_W-1:0];
                REG_CEILING:    r_ceiling    <= i_cfg_data;
                default:        r_ceiling    <= r_ceiling;
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_position      = r_pos;
    assign o_city          = r_city;
    assign o_leg_cost      = r_leg;
    assign o_total_cost    = r_total;
    assign o_last          = r_last;
    assign o_no_city_error = r_err;

endmodule
